// File: hdl/ids_pkg.sv
// ----------------------------------------------------------------------------
// Image difference statistics package
// Shared widths, mode and register codes, and the divider request and
// response types.
// ----------------------------------------------------------------------------
package ids_pkg;

    // Sample pixel count limit and component limit.
    localparam int MAX_PIXELS_LOG2 = 24;
    localparam int MAX_COMPONENTS  = 16;

    localparam int CNT_W    = MAX_PIXELS_LOG2 + 1;   // component pixel count
    localparam int COMP_W   = 5;                     // component count
    localparam int CACC_W   = 58;                    // component accumulator
    localparam int IACC_W   = 54;                    // image accumulator
    localparam int RES_W    = 49;                    // result, 16 fraction bits
    localparam int SAMP_W   = 33;                    // decoded sample
    localparam int NUM_W    = 73;                    // divider numerator
    localparam int DEN_W    = CNT_W;                 // divider denominator
    localparam int STEP_W   = 7;                     // divider step counter

    localparam logic [STEP_W-1:0] DIV_LAST_STEP = STEP_W'(NUM_W - 1);

    // Measure modes.
    localparam logic [2:0] MODE_MIN_DIFF  = 3'd0;
    localparam logic [2:0] MODE_MAX_DIFF  = 3'd1;
    localparam logic [2:0] MODE_DRIFT     = 3'd2;
    localparam logic [2:0] MODE_MEAN_ABS  = 3'd3;
    localparam logic [2:0] MODE_PEAK_ABS  = 3'd4;
    localparam logic [2:0] MODE_MIN_ORIG  = 3'd5;
    localparam logic [2:0] MODE_MAX_ORIG  = 3'd6;

    // Configuration register indexes.
    localparam logic [1:0] CFG_MEASURE_MODE  = 2'd0;
    localparam logic [1:0] CFG_SAMPLE_SIGNED = 2'd1;
    localparam logic [1:0] CFG_SAMPLE_BITS   = 2'd2;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] numerator;
        logic [DEN_W-1:0] denominator;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] quotient;
    } div_rsp_t;

endpackage

// File: hdl/ids_divider.sv
// ----------------------------------------------------------------------------
// Serial divider
// Restoring unsigned division, one quotient bit per cycle. The numerator
// register shifts left and collects the quotient bits as it empties.
// ----------------------------------------------------------------------------
module ids_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  ids_pkg::div_req_t req,
    output ids_pkg::div_rsp_t rsp
);
    import ids_pkg::*;

    logic [NUM_W-1:0]  quo_reg, quo_next;
    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [DEN_W-1:0]  den_reg, den_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              fits;

    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = trial >= {1'b0, den_reg};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            quo_next  = req.numerator;
            rem_next  = '0;
            den_next  = req.denominator;
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // The remainder stays below the divisor, so it fits DEN_W bits.
            rem_next  = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_next  = {quo_reg[NUM_W-2:0], fits};
            step_next = step_reg + 1'b1;
            if (step_reg == DIV_LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// File: hdl/image_difference_statistics.sv
// ----------------------------------------------------------------------------
// Image difference statistics
// Per-component statistic of original/distorted sample pairs, folded into
// one image-wide result in signed fixed point with 16 fraction bits.
// ----------------------------------------------------------------------------
// A sample pair that does not end a component is taken without a stall,
// so a component streams at one word per clock through the shared
// add/compare unit. In the mean modes a word that ends a non-empty component
// holds the input off while the 73-step serial divider is started, its
// quotient is awaited and the component result is folded into the image
// result. The other modes skip the divider and go straight to the fold. A
// word that ends the image then adds the image mean division in the mean
// modes and the load of the output register, and holds the input longer
// while an earlier result still waits in the output register. The input
// stalls while these end-of-component and end-of-image steps run. A finished
// result waits in the output register while the next image streams in.
// ----------------------------------------------------------------------------
module image_difference_statistics (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration write port
    input  logic                            cfg_we,
    input  logic [1:0]                      cfg_index,
    input  logic [5:0]                      cfg_data,
    // sample pair channel
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [31:0]                     original_sample,
    input  logic [31:0]                     distorted_sample,
    input  logic                            last_of_component,
    input  logic                            last_of_image,
    // result channel
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic signed [ids_pkg::RES_W-1:0] result_value,
    output logic                            empty_component_error
);
    import ids_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_COMP,
        S_CDIV,
        S_FOLD,
        S_IMG,
        S_IDIV,
        S_OUT
    } state_t;

    localparam logic signed [RES_W-1:0]  RES_MAX = {1'b0, {(RES_W-1){1'b1}}};
    localparam logic signed [RES_W-1:0]  RES_MIN = {1'b1, {(RES_W-1){1'b0}}};
    localparam logic signed [CACC_W-1:0] SAMP_HI = CACC_W'(64'sd8589934592);
    localparam logic signed [CACC_W-1:0] SAMP_LO = CACC_W'(-64'sd8589934592);
    localparam logic signed [CACC_W-1:0] CR_HI   = CACC_W'(64'sd4294967296);
    localparam logic signed [CACC_W-1:0] CR_LO   = CACC_W'(-64'sd4294967296);

    state_t                     state_reg, state_next;
    logic [2:0]                 mode_reg, mode_next;
    logic                       signed_reg, signed_next;
    logic [5:0]                 bits_reg, bits_next;
    logic signed [CACC_W-1:0]   cacc_reg, cacc_next;
    logic [CNT_W-1:0]           ccnt_reg, ccnt_next;
    logic signed [IACC_W-1:0]   iacc_reg, iacc_next;
    logic [COMP_W-1:0]          ncomp_reg, ncomp_next;
    logic                       err_reg, err_next;
    logic                       last_img_reg, last_img_next;
    logic signed [RES_W-1:0]    cr_reg, cr_next;
    logic signed [RES_W-1:0]    res_reg, res_next;
    logic                       div_neg_reg, div_neg_next;
    logic                       out_valid_reg, out_valid_next;
    logic signed [RES_W-1:0]    out_value_reg, out_value_next;
    logic                       out_err_reg, out_err_next;

    logic [1:0]                 cw_sel;
    logic signed [SAMP_W-1:0]   orig_dec, dist_dec;
    logic signed [SAMP_W:0]     diff_wide;
    logic signed [SAMP_W-1:0]   diff_val, abs_val, operand;
    logic signed [CACC_W-1:0]   op_ext, acc_sum;
    logic                       op_lt, op_gt;
    logic                       mean_mode;
    logic                       restart;
    logic [CACC_W-1:0]          cmag;
    logic [IACC_W-1:0]          imag;
    logic signed [RES_W-1:0]    div_res;
    logic signed [RES_W-1:0]    cr_plain;
    logic signed [IACC_W-1:0]   cr_ext;
    div_req_t                   div_req;
    div_rsp_t                   div_rsp;

    function automatic logic signed [SAMP_W-1:0] decode(
        input logic [31:0] raw,
        input logic [1:0]  sel,
        input logic        sgn
    );
        logic signed [SAMP_W-1:0] v;
        case (sel)
            2'd0:    v = {{25{sgn & raw[7]}}, raw[7:0]};
            2'd1:    v = {{17{sgn & raw[15]}}, raw[15:0]};
            default: v = {sgn & raw[31], raw};
        endcase
        return v;
    endfunction

    function automatic logic signed [CACC_W-1:0] comp_start(input logic [2:0] m);
        logic signed [CACC_W-1:0] v;
        v = '0;
        if (m == MODE_MIN_ORIG)
        begin
            v = SAMP_HI;
        end
        else if (m == MODE_MAX_ORIG)
        begin
            v = SAMP_LO;
        end
        return v;
    endfunction

    function automatic logic signed [IACC_W-1:0] image_start(input logic [2:0] m);
        logic signed [IACC_W-1:0] v;
        v = '0;
        if (m == MODE_MIN_ORIG)
        begin
            v = {{(IACC_W-RES_W){RES_MAX[RES_W-1]}}, RES_MAX};
        end
        else if (m == MODE_MAX_ORIG)
        begin
            v = {{(IACC_W-RES_W){RES_MIN[RES_W-1]}}, RES_MIN};
        end
        return v;
    endfunction

    // Container width: 8 bits up to depth 8 (depth 0 too), 16 up to 16, else 32.
    always_comb
    begin
        if (bits_reg <= 6'd8)
        begin
            cw_sel = 2'd0;
        end
        else if (bits_reg <= 6'd16)
        begin
            cw_sel = 2'd1;
        end
        else
        begin
            cw_sel = 2'd2;
        end
    end

    assign orig_dec  = decode(original_sample, cw_sel, signed_reg);
    assign dist_dec  = decode(distorted_sample, cw_sel, signed_reg);
    // Both samples share one signedness, so the difference fits SAMP_W bits.
    assign diff_wide = {orig_dec[SAMP_W-1], orig_dec} - {dist_dec[SAMP_W-1], dist_dec};
    assign diff_val  = diff_wide[SAMP_W-1:0];
    assign abs_val   = diff_val[SAMP_W-1] ? -diff_val : diff_val;

    // Shared add/compare unit of the accumulate step.
    always_comb
    begin
        case (mode_reg) inside
            MODE_MIN_ORIG, MODE_MAX_ORIG: operand = orig_dec;
            MODE_MEAN_ABS, MODE_PEAK_ABS: operand = abs_val;
            default:                      operand = diff_val;
        endcase
    end

    assign op_ext  = {{(CACC_W-SAMP_W){operand[SAMP_W-1]}}, operand};
    assign acc_sum = cacc_reg + op_ext;
    assign op_lt   = op_ext < cacc_reg;
    assign op_gt   = op_ext > cacc_reg;

    assign mean_mode = (mode_reg == MODE_DRIFT) || (mode_reg == MODE_MEAN_ABS);

    // Component result for the min/max modes: value times 2^16, saturated.
    always_comb
    begin
        if (cacc_reg >= CR_HI)
        begin
            cr_plain = RES_MAX;
        end
        else if (cacc_reg <= CR_LO)
        begin
            cr_plain = RES_MIN;
        end
        else
        begin
            cr_plain = {cacc_reg[SAMP_W-1:0], 16'b0};
        end
    end

    assign cmag   = cacc_reg[CACC_W-1] ? CACC_W'(-cacc_reg) : CACC_W'(cacc_reg);
    assign imag   = iacc_reg[IACC_W-1] ? IACC_W'(-iacc_reg) : IACC_W'(iacc_reg);
    assign cr_ext = {{(IACC_W-RES_W){cr_reg[RES_W-1]}}, cr_reg};

    // Quotient magnitudes of 2^48 and above saturate; the result then takes the sign back.
    always_comb
    begin
        if (|div_rsp.quotient[NUM_W-1:RES_W-1])
        begin
            div_res = div_neg_reg ? RES_MIN : RES_MAX;
        end
        else if (div_neg_reg)
        begin
            div_res = -$signed({1'b0, div_rsp.quotient[RES_W-2:0]});
        end
        else
        begin
            div_res = $signed({1'b0, div_rsp.quotient[RES_W-2:0]});
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        signed_next    = signed_reg;
        bits_next      = bits_reg;
        cacc_next      = cacc_reg;
        ccnt_next      = ccnt_reg;
        iacc_next      = iacc_reg;
        ncomp_next     = ncomp_reg;
        err_next       = err_reg;
        last_img_next  = last_img_reg;
        cr_next        = cr_reg;
        res_next       = res_reg;
        div_neg_next   = div_neg_reg;
        out_valid_next = out_valid_reg;
        out_value_next = out_value_reg;
        out_err_next   = out_err_reg;
        restart        = 1'b0;
        div_req        = '0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    // Samples beyond the pixel limit of a component are dropped.
                    if (!ccnt_reg[CNT_W-1])
                    begin
                        ccnt_next = ccnt_reg + 1'b1;
                        case (mode_reg) inside
                            MODE_MIN_DIFF, MODE_MIN_ORIG:
                                if (op_lt) cacc_next = op_ext;
                            MODE_MAX_DIFF, MODE_PEAK_ABS, MODE_MAX_ORIG:
                                if (op_gt) cacc_next = op_ext;
                            MODE_DRIFT, MODE_MEAN_ABS:
                                cacc_next = acc_sum;
                            default:
                                cacc_next = cacc_reg;
                        endcase
                    end
                    last_img_next = last_of_image;
                    if (last_of_component || last_of_image)
                    begin
                        state_next = S_COMP;
                    end
                end
            end
            S_COMP:
            begin
                if (mean_mode)
                begin
                    if (ccnt_reg == '0)
                    begin
                        err_next   = 1'b1;
                        cr_next    = '0;
                        state_next = S_FOLD;
                    end
                    else
                    begin
                        // (|sum| * 2^16 + count/2) / count rounds half away from zero.
                        div_req.start       = 1'b1;
                        div_req.numerator   = {cmag[NUM_W-17:0], 16'b0}
                                            + NUM_W'(ccnt_reg >> 1);
                        div_req.denominator = ccnt_reg;
                        div_neg_next        = cacc_reg[CACC_W-1];
                        state_next          = S_CDIV;
                    end
                end
                else if (mode_reg <= MODE_MAX_ORIG)
                begin
                    cr_next    = cr_plain;
                    state_next = S_FOLD;
                end
                else
                begin
                    cr_next    = '0;
                    state_next = S_FOLD;
                end
            end
            S_CDIV:
            begin
                if (div_rsp.done)
                begin
                    cr_next    = div_res;
                    state_next = S_FOLD;
                end
            end
            S_FOLD:
            begin
                if (ncomp_reg < COMP_W'(MAX_COMPONENTS))
                begin
                    ncomp_next = ncomp_reg + 1'b1;
                    case (mode_reg) inside
                        MODE_MIN_DIFF, MODE_MIN_ORIG:
                            if (cr_ext < iacc_reg) iacc_next = cr_ext;
                        MODE_MAX_DIFF, MODE_PEAK_ABS, MODE_MAX_ORIG:
                            if (cr_ext > iacc_reg) iacc_next = cr_ext;
                        MODE_DRIFT, MODE_MEAN_ABS:
                            iacc_next = iacc_reg + cr_ext;
                        default:
                            iacc_next = iacc_reg;
                    endcase
                end
                cacc_next  = comp_start(mode_reg);
                ccnt_next  = '0;
                state_next = last_img_reg ? S_IMG : S_IDLE;
            end
            S_IMG:
            begin
                if (mean_mode)
                begin
                    if (ncomp_reg == '0)
                    begin
                        err_next   = 1'b1;
                        res_next   = '0;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        div_req.start       = 1'b1;
                        div_req.numerator   = NUM_W'(imag) + NUM_W'(ncomp_reg >> 1);
                        div_req.denominator = DEN_W'(ncomp_reg);
                        div_neg_next        = iacc_reg[IACC_W-1];
                        state_next          = S_IDIV;
                    end
                end
                else if (mode_reg <= MODE_MAX_ORIG)
                begin
                    // Min/max image results never leave the result range.
                    res_next   = iacc_reg[RES_W-1:0];
                    state_next = S_OUT;
                end
                else
                begin
                    res_next   = '0;
                    state_next = S_OUT;
                end
            end
            S_IDIV:
            begin
                if (div_rsp.done)
                begin
                    res_next   = div_res;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = res_reg;
                    out_err_next   = err_reg;
                    restart        = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Any register write restarts the current image.
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MEASURE_MODE:
                begin
                    mode_next = cfg_data[2:0];
                    restart   = 1'b1;
                end
                CFG_SAMPLE_SIGNED:
                begin
                    signed_next = cfg_data[0];
                    restart     = 1'b1;
                end
                CFG_SAMPLE_BITS:
                begin
                    bits_next = cfg_data;
                    restart   = 1'b1;
                end
                default:
                begin
                    restart = restart;
                end
            endcase
        end

        if (restart)
        begin
            cacc_next  = comp_start(mode_next);
            ccnt_next  = '0;
            iacc_next  = image_start(mode_next);
            ncomp_next = '0;
            err_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_reg      <= MODE_PEAK_ABS;
            signed_reg    <= 1'b0;
            bits_reg      <= 6'd8;
            cacc_reg      <= comp_start(MODE_PEAK_ABS);
            ccnt_reg      <= '0;
            iacc_reg      <= image_start(MODE_PEAK_ABS);
            ncomp_reg     <= '0;
            err_reg       <= 1'b0;
            last_img_reg  <= 1'b0;
            cr_reg        <= '0;
            res_reg       <= '0;
            div_neg_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            out_value_reg <= '0;
            out_err_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            signed_reg    <= signed_next;
            bits_reg      <= bits_next;
            cacc_reg      <= cacc_next;
            ccnt_reg      <= ccnt_next;
            iacc_reg      <= iacc_next;
            ncomp_reg     <= ncomp_next;
            err_reg       <= err_next;
            last_img_reg  <= last_img_next;
            cr_reg        <= cr_next;
            res_reg       <= res_next;
            div_neg_reg   <= div_neg_next;
            out_valid_reg <= out_valid_next;
            out_value_reg <= out_value_next;
            out_err_reg   <= out_err_next;
        end
    end

    ids_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign in_stall              = (state_reg != S_IDLE);
    assign out_valid             = out_valid_reg;
    assign result_value          = out_value_reg;
    assign empty_component_error = out_err_reg;

endmodule
